// File: rtl/rraw_pkg.sv
// shared types and constants for the receive reorder ack window
package rraw_pkg;
    localparam int SLOTS = 64;
    localparam int MAX_LEN = 2048;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W = 7;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP = 2'd1;
    localparam logic [1:0] OP_SKIP = 2'd2;
    localparam logic [1:0] OP_CONTAINS = 2'd3;

    localparam logic [1:0] REG_EPOCH = 2'd0;
    localparam logic [1:0] REG_FIRST = 2'd1;
    localparam logic [1:0] REG_SLOTS = 2'd2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_TOO_LONG = 3'd2;
    localparam logic [2:0] ST_ALREADY = 3'd3;
    localparam logic [2:0] ST_RANGE = 3'd4;
    localparam logic [2:0] ST_NO_SPACE = 3'd5;
    localparam logic [2:0] ST_NOT_READY = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_READ, S_WAIT, S_APPLY, S_SLIDE, S_DONE
    } t_state;

    function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction
endpackage

// File: rtl/rraw_slot_ram.sv
// descriptor storage: sequence, length and handle per slot
module rraw_slot_ram (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [rraw_pkg::SLOT_W-1:0] i_waddr,
    input  logic [79:0]                 i_wdata,
    input  logic [rraw_pkg::SLOT_W-1:0] i_raddr,
    output logic [79:0]                 o_rdata
);
    logic [79:0] r_mem [rraw_pkg::SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/rx_reorder_ack_window.sv
// top level: reorder window with selective-ack bitmap
// One transaction is taken when i_start is high and o_busy low. The slots are
// walked one per cycle through a single descriptor memory read port. Pop, contains
// and a refused insert keep o_busy high while the active slots are scanned, and the
// next transaction can go in once o_busy is low again. A stored insert then slides
// the ack base step by step (up to 64 steps), and a skip slides it the same way
// after its scan. A stale skip, or a skip while the slot count is out of range,
// goes straight to the result; any other operation with the slot count out of range
// skips the scan. The result shows for one cycle with o_done as o_busy drops, and the
// receiver cannot stall it. A write of the epoch or slot count register clears the
// window at once.
module rx_reorder_ack_window (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_sequence_req,
    input  logic [15:0] i_length,
    input  logic [31:0] i_payload_handle,
    input  logic [15:0] i_buffer_capacity,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [31:0] o_out_sequence,
    output logic [15:0] o_out_length,
    output logic [31:0] o_out_handle,
    output logic        o_found,
    output logic [31:0] o_cum_ack,
    output logic [63:0] o_sack_bits,
    output logic [6:0]  o_held_count
);
    localparam int SW = rraw_pkg::SLOT_W;

    rraw_pkg::t_state r_state, n_state;
    logic [15:0] r_epoch;
    logic [31:0] r_first;
    logic [6:0]  r_nslots;
    logic [rraw_pkg::SLOTS-1:0] r_valid, n_valid;
    logic [31:0] r_base, n_base, r_rel, n_rel;
    logic [63:0] r_bits, n_bits;
    logic [6:0]  r_occ, n_occ;
    logic [1:0]  r_op;
    logic [31:0] r_seq, r_hnd;
    logic [15:0] r_len, r_cap;
    logic [6:0]  r_idx, n_idx;
    logic [SW:0] r_hit, n_hit, r_free, n_free;
    logic [2:0]  r_status, n_status;
    logic        r_done, n_done;
    logic [31:0] r_oseq, n_oseq, r_ohnd, n_ohnd;
    logic [15:0] r_olen, n_olen;
    logic        r_found, n_found;

    logic        ram_we;
    logic [SW-1:0] ram_waddr, ram_raddr;
    logic [79:0] ram_wdata, ram_rdata;
    logic [6:0]  active;
    logic [31:0] key, rd_seq, slot_dist;
    logic [15:0] rd_len;
    logic        rd_v;
    logic        cfg_clear;

    rraw_slot_ram u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    assign active = (r_nslots == 7'd0 || r_nslots > 7'(rraw_pkg::SLOTS)) ? 7'd0 : r_nslots;
    assign cfg_clear = i_cfg_we && (i_cfg_index == rraw_pkg::REG_EPOCH ||
                                    i_cfg_index == rraw_pkg::REG_SLOTS);
    assign key = (r_op == rraw_pkg::OP_POP) ? r_rel : r_seq;
    assign rd_seq = ram_rdata[79:48];
    assign rd_len = ram_rdata[47:32];
    // r_idx is one ahead of the slot whose data sits on the read port
    assign rd_v = r_valid[SW'(r_idx - 7'd1)];
    assign slot_dist = rd_seq - r_base;

    always_comb begin
        n_state = r_state; n_valid = r_valid; n_base = r_base; n_rel = r_rel;
        n_bits = r_bits; n_occ = r_occ; n_idx = r_idx; n_hit = r_hit; n_free = r_free;
        n_status = r_status; n_done = 1'b0; n_oseq = r_oseq; n_olen = r_olen;
        n_ohnd = r_ohnd; n_found = r_found;
        ram_we = 1'b0; ram_waddr = r_free[SW-1:0];
        ram_wdata = {r_seq, r_len, r_hnd};
        ram_raddr = r_idx[SW-1:0];
        unique case (r_state)
            rraw_pkg::S_IDLE: begin
                if (i_start) begin
                    n_idx = 7'd0; n_hit = '1; n_free = '1;
                    n_status = rraw_pkg::ST_OK; n_oseq = '0; n_olen = '0;
                    n_ohnd = '0; n_found = 1'b0;
                    if (i_opcode == rraw_pkg::OP_SKIP) begin
                        if (active != 7'd0 && !rraw_pkg::seq_before(i_sequence_req, r_rel)) begin
                            n_rel = i_sequence_req;
                            n_base = i_sequence_req - 32'd1;
                            n_bits = '0;
                            n_state = rraw_pkg::S_SCAN;
                        end else begin
                            n_state = rraw_pkg::S_DONE;
                        end
                    end else begin
                        n_state = (active == 7'd0) ? rraw_pkg::S_APPLY : rraw_pkg::S_SCAN;
                    end
                end
            end
            rraw_pkg::S_SCAN: begin
                // issue read of slot r_idx
                n_idx = r_idx + 7'd1;
                n_state = rraw_pkg::S_READ;
            end
            rraw_pkg::S_READ: begin
                if (r_op == rraw_pkg::OP_SKIP) begin
                    if (rd_v) begin
                        if (rraw_pkg::seq_before(rd_seq, r_rel) || slot_dist == 32'd0 ||
                            slot_dist > 32'd64) begin
                            n_valid[SW'(r_idx - 7'd1)] = 1'b0;
                            if (n_occ != 7'd0) n_occ = r_occ - 7'd1;
                        end else begin
                            n_bits = r_bits | (64'd1 << 6'(slot_dist - 32'd1));
                        end
                    end
                end else begin
                    if (rd_v && rd_seq == key && r_hit[SW])
                        n_hit = {1'b0, SW'(r_idx - 7'd1)};
                    if (!rd_v && r_free[SW])
                        n_free = {1'b0, SW'(r_idx - 7'd1)};
                end
                if (r_idx >= active) begin
                    n_state = rraw_pkg::S_APPLY;
                    ram_raddr = n_hit[SW-1:0];
                    if (r_op == rraw_pkg::OP_SKIP) n_state = rraw_pkg::S_SLIDE;
                    else if (r_op == rraw_pkg::OP_POP && !n_hit[SW]) n_state = rraw_pkg::S_WAIT;
                end else begin
                    n_idx = r_idx + 7'd1;
                end
            end
            rraw_pkg::S_WAIT: begin
                // hit slot data now on the read port
                if (r_cap < rd_len) begin
                    n_status = rraw_pkg::ST_TOO_LONG;
                end else begin
                    n_oseq = rd_seq; n_olen = rd_len; n_ohnd = ram_rdata[31:0];
                    n_valid[r_hit[SW-1:0]] = 1'b0;
                    if (r_occ != 7'd0) n_occ = r_occ - 7'd1;
                    n_rel = r_rel + 32'd1;
                end
                n_state = rraw_pkg::S_DONE;
            end
            rraw_pkg::S_APPLY: begin
                n_state = rraw_pkg::S_DONE;
                unique case (r_op)
                    rraw_pkg::OP_INSERT: begin
                        if (r_epoch == 16'd0 || active == 7'd0) begin
                            n_status = rraw_pkg::ST_INVALID;
                        end else if (r_len > 16'(rraw_pkg::MAX_LEN)) begin
                            n_status = rraw_pkg::ST_TOO_LONG;
                        end else if (r_seq == r_base || rraw_pkg::seq_before(r_seq, r_base)
                                     || !r_hit[SW]) begin
                            n_status = rraw_pkg::ST_ALREADY;
                        end else if ((r_seq - r_base) > 32'd64) begin
                            n_status = rraw_pkg::ST_RANGE;
                        end else if (r_free[SW]) begin
                            n_status = rraw_pkg::ST_NO_SPACE;
                        end else begin
                            ram_we = 1'b1;
                            n_valid[r_free[SW-1:0]] = 1'b1;
                            n_occ = r_occ + 7'd1;
                            n_bits = r_bits | (64'd1 << 6'(r_seq - r_base - 32'd1));
                            n_state = rraw_pkg::S_SLIDE;
                        end
                    end
                    rraw_pkg::OP_POP: n_status = rraw_pkg::ST_NOT_READY;
                    rraw_pkg::OP_CONTAINS: n_found = !r_hit[SW];
                    default: ;
                endcase
            end
            rraw_pkg::S_SLIDE: begin
                if (r_bits[0]) begin
                    n_base = r_base + 32'd1;
                    n_bits = {1'b0, r_bits[63:1]};
                end else begin
                    n_state = rraw_pkg::S_DONE;
                end
            end
            rraw_pkg::S_DONE: begin
                n_done = 1'b1;
                n_state = rraw_pkg::S_IDLE;
            end
            default: n_state = rraw_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rraw_pkg::S_IDLE;
            r_epoch <= '0; r_first <= '0; r_nslots <= 7'd64;
            r_valid <= '0; r_base <= '1; r_bits <= '0; r_rel <= '0; r_occ <= '0;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state; r_done <= n_done;
            r_valid <= n_valid; r_base <= n_base; r_bits <= n_bits;
            r_rel <= n_rel; r_occ <= n_occ;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rraw_pkg::REG_EPOCH: r_epoch <= i_cfg_data[15:0];
                    rraw_pkg::REG_FIRST: r_first <= i_cfg_data;
                    rraw_pkg::REG_SLOTS: r_nslots <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (cfg_clear) begin
                r_valid <= '0; r_base <= r_first - 32'd1; r_bits <= '0;
                r_rel <= r_first; r_occ <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_hit <= n_hit; r_free <= n_free; r_status <= n_status;
        r_oseq <= n_oseq; r_olen <= n_olen; r_ohnd <= n_ohnd; r_found <= n_found;
        if (r_state == rraw_pkg::S_IDLE && i_start) begin
            r_op <= i_opcode; r_seq <= i_sequence_req; r_len <= i_length;
            r_hnd <= i_payload_handle; r_cap <= i_buffer_capacity;
        end
    end

    assign o_busy = (r_state != rraw_pkg::S_IDLE);
    assign o_done = r_done;
    assign o_status = r_status;
    assign o_out_sequence = r_oseq;
    assign o_out_length = r_olen;
    assign o_out_handle = r_ohnd;
    assign o_found = r_found;
    assign o_cum_ack = r_base;
    assign o_sack_bits = r_bits;
    assign o_held_count = r_occ;
endmodule

// File: rtl/rraw_checker.sv
// port-level checks for the reorder window, bound to the top level
module rraw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_done,
    input logic [2:0] o_status,
    input logic       o_found,
    input logic [6:0] o_held_count
);
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("start not taken");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("done while busy");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status <= rraw_pkg::ST_NOT_READY && o_held_count <= 7'd64))
        else $error("bad result");
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_found) |-> o_status == rraw_pkg::ST_OK) else $error("found with error");
endmodule

bind rx_reorder_ack_window rraw_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_done(o_done), .o_status(o_status), .o_found(o_found), .o_held_count(o_held_count)
);

// File: tb/sv/testbench.sv
// testbench for rx_reorder_ack_window: directed table, then random transactions vs a predictor
`timescale 1ns / 1ps

module testbench;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SPAN = 64;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_sequence;
        logic [15:0] out_length;
        logic [31:0] out_handle;
        logic        found;
        logic [31:0] cum_ack;
        logic [63:0] sack_bits;
        logic [6:0]  held_count;
    } t_window_result;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  code;
        logic [31:0] seq;
        logic [15:0] len;
        logic [31:0] hdl;
        logic [15:0] cap;
        bit          fixed;
        logic [2:0]  status;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic [1:0]  i_opcode;
    logic [31:0] i_sequence_req;
    logic [15:0] i_length;
    logic [31:0] i_payload_handle;
    logic [15:0] i_buffer_capacity;
    logic        o_done;
    logic [2:0]  o_status;
    logic [31:0] o_out_sequence;
    logic [15:0] o_out_length;
    logic [31:0] o_out_handle;
    logic        o_found;
    logic [31:0] o_cum_ack;
    logic [63:0] o_sack_bits;
    logic [6:0]  o_held_count;

    rx_reorder_ack_window dut (.*);

    // window model state
    bit          slot_held[rraw_pkg::SLOTS];
    logic [31:0] slot_seq[rraw_pkg::SLOTS];
    logic [15:0] slot_len[rraw_pkg::SLOTS];
    logic [31:0] slot_hdl[rraw_pkg::SLOTS];
    logic [31:0] win_base;
    logic [63:0] win_bits;
    logic [31:0] win_release;
    int          win_held;
    logic [15:0] cfg_epoch;
    logic [31:0] cfg_first;
    logic [6:0]  cfg_slots;

    t_window_result pending_results[$];
    t_stim_row      stim_table[$];
    int             fail_count = 0;
    int             cycle_count = 0;
    int             burst_left;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic bit wraps_before(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic int live_slots();
        return (cfg_slots == 0 || cfg_slots > rraw_pkg::SLOTS) ? 0 : int'(cfg_slots);
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < rraw_pkg::SLOTS; i++) slot_held[i] = 1'b0;
        win_base = cfg_first - 32'd1;
        win_bits = '0;
        win_release = cfg_first;
        win_held = 0;
    endfunction

    function automatic int held_index(logic [31:0] s);
        for (int i = 0; i < live_slots(); i++)
            if (slot_held[i] && slot_seq[i] == s) return i;
        return -1;
    endfunction

    function automatic void slide_ack();
        while (win_bits[0]) begin
            win_base = win_base + 32'd1;
            win_bits = win_bits >> 1;
        end
    endfunction

    function automatic void release_slot(int i);
        slot_held[i] = 1'b0;
        if (win_held > 0) win_held--;
    endfunction

    function automatic logic [2:0] model_insert(logic [31:0] s, logic [15:0] len,
                                                logic [31:0] hdl);
        logic [31:0] span_off;
        int          free_idx;
        free_idx = -1;
        if (cfg_epoch == 0 || live_slots() == 0) return rraw_pkg::ST_INVALID;
        if (len > rraw_pkg::MAX_LEN) return rraw_pkg::ST_TOO_LONG;
        if (s == win_base || wraps_before(s, win_base) || held_index(s) >= 0)
            return rraw_pkg::ST_ALREADY;
        span_off = s - win_base;
        if (span_off == 0 || span_off > SPAN) return rraw_pkg::ST_RANGE;
        for (int i = live_slots() - 1; i >= 0; i--)
            if (!slot_held[i]) free_idx = i;
        if (free_idx < 0) return rraw_pkg::ST_NO_SPACE;
        slot_held[free_idx] = 1'b1;
        slot_seq[free_idx] = s;
        slot_len[free_idx] = len;
        slot_hdl[free_idx] = hdl;
        win_held++;
        win_bits = win_bits | (64'd1 << (span_off - 1));
        slide_ack();
        return rraw_pkg::ST_OK;
    endfunction

    function automatic void model_skip(logic [31:0] target);
        logic [31:0] span_off;
        if (live_slots() == 0 || wraps_before(target, win_release)) return;
        win_release = target;
        win_base = target - 32'd1;
        win_bits = '0;
        for (int i = 0; i < live_slots(); i++) begin
            if (slot_held[i]) begin
                span_off = slot_seq[i] - win_base;
                if (wraps_before(slot_seq[i], target) || span_off == 0 || span_off > SPAN)
                    release_slot(i);
                else
                    win_bits = win_bits | (64'd1 << (span_off - 1));
            end
        end
        slide_ack();
    endfunction

    function automatic t_window_result predict_window(logic [1:0] op, logic [31:0] s,
                                                      logic [15:0] len, logic [31:0] hdl,
                                                      logic [15:0] cap);
        t_window_result r;
        int             k;
        r = '0;
        case (op)
            rraw_pkg::OP_INSERT: r.status = model_insert(s, len, hdl);
            rraw_pkg::OP_POP: begin
                k = held_index(win_release);
                if (k < 0) begin
                    r.status = rraw_pkg::ST_NOT_READY;
                end else if (cap < slot_len[k]) begin
                    r.status = rraw_pkg::ST_TOO_LONG;
                end else begin
                    r.out_sequence = slot_seq[k];
                    r.out_length = slot_len[k];
                    r.out_handle = slot_hdl[k];
                    release_slot(k);
                    win_release = win_release + 32'd1;
                end
            end
            rraw_pkg::OP_SKIP: model_skip(s);
            default: r.found = (held_index(s) >= 0);
        endcase
        r.cum_ack = win_base;
        r.sack_bits = win_bits;
        r.held_count = 7'(win_held);
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    // results can't be held off, so every o_done cycle is checked here
    always @(posedge i_clk) begin
        t_window_result e;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("result with no transaction outstanding");
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                check_field("status", e.status, o_status);
                check_field("out_sequence", e.out_sequence, o_out_sequence);
                check_field("out_length", e.out_length, o_out_length);
                check_field("out_handle", e.out_handle, o_out_handle);
                check_field("found", e.found, o_found);
                check_field("cum_ack", e.cum_ack, o_cum_ack);
                check_field("sack_bits", e.sack_bits, o_sack_bits);
                check_field("held_count", e.held_count, o_held_count);
            end
        end
    end

    // called at a falling edge; returns at a later falling edge after acceptance
    task automatic send_op(logic [1:0] op, logic [31:0] s, logic [15:0] len, logic [31:0] hdl,
                           logic [15:0] cap, bit fixed = 0,
                           logic [2:0] st = rraw_pkg::ST_OK);
        t_window_result r;
        i_opcode = op;
        i_sequence_req = s;
        i_length = len;
        i_payload_handle = hdl;
        i_buffer_capacity = cap;
        i_start = 1'b1;
        do @(posedge i_clk); while (o_busy);
        r = predict_window(op, s, len, hdl, cap);
        if (fixed) r.status = st;
        pending_results.push_back(r);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_start = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 8);
        end
    endtask

    task automatic drain();
        i_start = 1'b0;
        while (pending_results.size() != 0 || o_busy) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            rraw_pkg::REG_EPOCH: begin
                cfg_epoch = data[15:0];
                clear_window();
            end
            rraw_pkg::REG_FIRST: cfg_first = data;
            default: begin
                cfg_slots = data[6:0];
                clear_window();
            end
        endcase
    endtask

    function automatic void add_cfg(logic [1:0] idx, logic [31:0] data);
        t_stim_row r;
        r = '{is_cfg: 1, code: idx, seq: data, default: '0};
        stim_table.push_back(r);
    endfunction

    function automatic void add_op(logic [1:0] op, logic [31:0] s, logic [15:0] len,
                                   logic [31:0] hdl, logic [15:0] cap,
                                   bit fixed = 0, logic [2:0] st = rraw_pkg::ST_OK);
        t_stim_row r;
        r = '{is_cfg: 0, code: op, seq: s, len: len, hdl: hdl, cap: cap,
              fixed: fixed, status: st};
        stim_table.push_back(r);
    endfunction

    function automatic void build_table();
        // epoch zero after reset
        add_op(rraw_pkg::OP_INSERT, 32'd0, 16'd0, 32'd0, 16'd0, 1, rraw_pkg::ST_INVALID);
        add_op(rraw_pkg::OP_POP, 32'd0, 16'd0, 32'd0, 16'd0, 1, rraw_pkg::ST_NOT_READY);
        add_op(rraw_pkg::OP_CONTAINS, 32'd0, 16'd0, 32'd0, 16'd0);
        add_op(rraw_pkg::OP_SKIP, 32'd5, 16'd0, 32'd0, 16'd0);
        // window straddling the sequence wrap
        add_cfg(rraw_pkg::REG_FIRST, 32'hFFFF_FFFE);
        add_cfg(rraw_pkg::REG_EPOCH, 32'd1);
        add_op(rraw_pkg::OP_INSERT, 32'hFFFF_FFFE, 16'd2049, 32'd1, 16'd0, 1,
               rraw_pkg::ST_TOO_LONG);
        add_op(rraw_pkg::OP_INSERT, 32'hFFFF_FFFD, 16'd1, 32'd1, 16'd0, 1,
               rraw_pkg::ST_ALREADY);
        add_op(rraw_pkg::OP_INSERT, 32'h0000_003E, 16'd1, 32'd1, 16'd0, 1,
               rraw_pkg::ST_RANGE);
        add_op(rraw_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'd2048, 32'hFFFF_FFFF, 16'd0, 1,
               rraw_pkg::ST_OK);
        add_op(rraw_pkg::OP_INSERT, 32'h0000_003D, 16'd0, 32'd0, 16'd0, 1, rraw_pkg::ST_OK);
        add_op(rraw_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'd5, 32'd2, 16'd0, 1,
               rraw_pkg::ST_ALREADY);
        add_op(rraw_pkg::OP_INSERT, 32'hFFFF_FFFE, 16'd1, 32'h5A5A_A5A5, 16'd0);
        add_op(rraw_pkg::OP_POP, 32'd0, 16'd0, 32'd0, 16'd0, 1, rraw_pkg::ST_TOO_LONG);
        add_op(rraw_pkg::OP_POP, 32'd0, 16'd0, 32'd0, 16'hFFFF);
        add_op(rraw_pkg::OP_POP, 32'd0, 16'd0, 32'd0, 16'd2047, 1, rraw_pkg::ST_TOO_LONG);
        add_op(rraw_pkg::OP_POP, 32'd0, 16'd0, 32'd0, 16'd2048);
        add_op(rraw_pkg::OP_POP, 32'd0, 16'd0, 32'd0, 16'hFFFF, 1, rraw_pkg::ST_NOT_READY);
        add_op(rraw_pkg::OP_CONTAINS, 32'h0000_003D, 16'd0, 32'd0, 16'd0);
        add_op(rraw_pkg::OP_CONTAINS, 32'hFFFF_FFFF, 16'd0, 32'd0, 16'd0);
        add_op(rraw_pkg::OP_SKIP, 32'h0000_0020, 16'd0, 32'd0, 16'd0);
        add_op(rraw_pkg::OP_SKIP, 32'h0000_0010, 16'd0, 32'd0, 16'd0);
        add_op(rraw_pkg::OP_SKIP, 32'h0001_0000, 16'd0, 32'd0, 16'd0);
        // single slot fills up
        add_cfg(rraw_pkg::REG_SLOTS, 32'd1);
        add_op(rraw_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'd7, 32'd3, 16'd0);
        add_op(rraw_pkg::OP_INSERT, 32'h0000_0000, 16'd7, 32'd4, 16'd0, 1,
               rraw_pkg::ST_NO_SPACE);
        // slot count out of range disables the window
        add_cfg(rraw_pkg::REG_SLOTS, 32'd0);
        add_op(rraw_pkg::OP_INSERT, 32'hFFFF_FFFE, 16'd7, 32'd3, 16'd0, 1,
               rraw_pkg::ST_INVALID);
        add_op(rraw_pkg::OP_POP, 32'd0, 16'd0, 32'd0, 16'hFFFF, 1, rraw_pkg::ST_NOT_READY);
        add_op(rraw_pkg::OP_SKIP, 32'd9, 16'd0, 32'd0, 16'd0);
        add_cfg(rraw_pkg::REG_SLOTS, 32'd127);
        add_op(rraw_pkg::OP_INSERT, 32'hFFFF_FFFE, 16'd7, 32'd3, 16'd0, 1,
               rraw_pkg::ST_INVALID);
        add_cfg(rraw_pkg::REG_SLOTS, 32'd64);
        add_cfg(rraw_pkg::REG_FIRST, 32'd0);
        add_cfg(rraw_pkg::REG_EPOCH, 32'hFFFF);
        add_op(rraw_pkg::OP_INSERT, 32'd0, 16'hFFFF, 32'd0, 16'd0, 1, rraw_pkg::ST_TOO_LONG);
    endfunction

    task automatic random_op();
        logic [1:0]  op;
        logic [31:0] s;
        logic [15:0] len;
        logic [15:0] cap;
        int          pick;
        pick = $urandom_range(0, 99);
        op = pick < 45 ? rraw_pkg::OP_INSERT : pick < 70 ? rraw_pkg::OP_POP
           : pick < 80 ? rraw_pkg::OP_SKIP : rraw_pkg::OP_CONTAINS;
        len = $urandom_range(0, 9) == 0 ? 16'($urandom)
                                        : 16'($urandom_range(0, rraw_pkg::MAX_LEN));
        cap = $urandom_range(0, 4) == 0 ? 16'($urandom_range(0, rraw_pkg::MAX_LEN))
                                        : 16'($urandom);
        if ($urandom_range(0, 99) < 12) begin
            s = $urandom;
        end else begin
            case (op)
                rraw_pkg::OP_INSERT:
                    s = $urandom_range(0, 9) == 0 ? win_base - $urandom_range(0, 4)
                                                  : win_base + $urandom_range(1, 66);
                rraw_pkg::OP_SKIP:
                    s = $urandom_range(0, 5) == 0 ? win_release - $urandom_range(1, 4)
                      : $urandom_range(0, 9) == 0 ? win_release + $urandom_range(60, 200)
                      : win_release + $urandom_range(0, 8);
                default: s = win_base + $urandom_range(0, 70);
            endcase
        end
        send_op(op, s, len, $urandom, cap);
    endtask

    initial begin
        int          phase_items[6];
        logic [6:0]  phase_slots[6];
        logic [31:0] first_val;
        phase_items = '{200, 60, 150, 40, 40, 260};
        phase_slots = '{7'd64, 7'd1, 7'd5, 7'd0, 7'd100, 7'd64};
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = rraw_pkg::REG_EPOCH;
        i_cfg_data = '0;
        i_opcode = rraw_pkg::OP_INSERT;
        i_sequence_req = '0;
        i_length = '0;
        i_payload_handle = '0;
        i_buffer_capacity = '0;
        burst_left = 0;
        cfg_epoch = '0;
        cfg_first = '0;
        cfg_slots = 7'd64;
        clear_window();
        build_table();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (stim_table[i]) begin
            if (stim_table[i].is_cfg)
                write_reg(stim_table[i].code, stim_table[i].seq);
            else
                send_op(stim_table[i].code, stim_table[i].seq, stim_table[i].len,
                        stim_table[i].hdl, stim_table[i].cap, stim_table[i].fixed,
                        stim_table[i].status);
        end

        for (int p = 0; p < 6; p++) begin
            case ($urandom_range(0, 3))
                0: first_val = 32'hFFFF_FFFF;
                1: first_val = 32'hFFFF_FFFF - $urandom_range(0, 40);
                default: first_val = $urandom;
            endcase
            write_reg(rraw_pkg::REG_FIRST, first_val);
            write_reg(rraw_pkg::REG_SLOTS, {25'd0, phase_slots[p]});
            write_reg(rraw_pkg::REG_EPOCH, p == 3 ? 32'd0 : p == 1 ? 32'hFFFF
                                                 : 32'($urandom_range(1, 65535)));
            for (int n = 0; n < phase_items[p]; n++) begin
                // let all outstanding transactions finish once
                if (p == 2 && n == 50) drain();
                random_op();
            end
        end

        drain();
        repeat (200) @(negedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
